[src/sbb_pkg.sv]
// Shared types and constants of the sprite bounding-box scanner.
// Holds the configuration and result structs, register indexes and result kinds.
// No dependencies.
package sbb_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int COORD_W    = $clog2(MAX_DIM);
    localparam int DIM_W      = COORD_W + 1;
    localparam int PIX_W      = 8;
    localparam int FLAG_W     = 6;
    localparam int KIND_W     = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = DIM_W;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TRANSPARENT  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MARK_INDEX   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RECT_INDEX   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_MODE_FLAGS   = 3'd5;

    // Bit positions inside mode_flags.
    localparam int FLAG_CHECK_MARK  = 0;
    localparam int FLAG_TRACK_RECT  = 1;
    localparam int FLAG_INTERNAL    = 2;
    localparam int FLAG_CROP        = 3;
    localparam int FLAG_MARGIN      = 4;
    localparam int FLAG_TRANS_FIRST = 5;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BOX   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MARK  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RECT  = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 13'd1;
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 13'd1;
    localparam logic [PIX_W-1:0]  RST_TRANSPARENT  = 8'h00;
    localparam logic [PIX_W-1:0]  RST_MARK_INDEX   = 8'hFF;
    localparam logic [PIX_W-1:0]  RST_RECT_INDEX   = 8'hFE;
    localparam logic [FLAG_W-1:0] RST_MODE_FLAGS   = 6'd29;

    typedef struct packed {
        logic [DIM_W-1:0]  frame_width;
        logic [DIM_W-1:0]  frame_height;
        logic [PIX_W-1:0]  transparent_index;
        logic [PIX_W-1:0]  mark_index;
        logic [PIX_W-1:0]  rect_index;
        logic [FLAG_W-1:0] mode_flags;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [PIX_W-1:0]   pixel_out;
        logic [COORD_W-1:0] coord_a;
        logic [COORD_W-1:0] coord_b;
        logic [COORD_W-1:0] coord_c;
        logic [COORD_W-1:0] coord_d;
        logic               found;
        logic               last;
    } t_result;

    // The three beats that follow the last pixel of a frame.
    typedef struct packed {
        t_result box;
        t_result mark;
        t_result rect;
    } t_summary;

    // Status of the output sequencer as seen by the top level.
    typedef struct packed {
        logic holding;
        logic summary_busy;
    } t_out_status;

endpackage

[src/sbb_cfg.sv]
// Configuration register file of the sprite bounding-box scanner.
// Depends on sbb_pkg for the register indexes, reset values and t_cfg.
module sbb_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sbb_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [sbb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output sbb_pkg::t_cfg                   o_cfg
);

    sbb_pkg::t_cfg r_cfg;
    sbb_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                sbb_pkg::REG_FRAME_WIDTH:  n_cfg.frame_width  = i_cfg_data;
                sbb_pkg::REG_FRAME_HEIGHT: n_cfg.frame_height = i_cfg_data;
                sbb_pkg::REG_TRANSPARENT:
                    n_cfg.transparent_index = i_cfg_data[sbb_pkg::PIX_W-1:0];
                sbb_pkg::REG_MARK_INDEX:
                    n_cfg.mark_index = i_cfg_data[sbb_pkg::PIX_W-1:0];
                sbb_pkg::REG_RECT_INDEX:
                    n_cfg.rect_index = i_cfg_data[sbb_pkg::PIX_W-1:0];
                sbb_pkg::REG_MODE_FLAGS:
                    n_cfg.mode_flags = i_cfg_data[sbb_pkg::FLAG_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width       <= sbb_pkg::RST_FRAME_WIDTH;
            r_cfg.frame_height      <= sbb_pkg::RST_FRAME_HEIGHT;
            r_cfg.transparent_index <= sbb_pkg::RST_TRANSPARENT;
            r_cfg.mark_index        <= sbb_pkg::RST_MARK_INDEX;
            r_cfg.rect_index        <= sbb_pkg::RST_RECT_INDEX;
            r_cfg.mode_flags        <= sbb_pkg::RST_MODE_FLAGS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/sbb_scan.sv]
// Scan state and per-pixel update of the sprite bounding-box scanner.
// Depends on sbb_pkg; produces the pixel beat and, at frame end, the summary beats.
module sbb_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sbb_pkg::t_cfg               i_cfg,
    input  logic                        i_accept,
    input  logic [sbb_pkg::PIX_W-1:0]   i_pixel,
    output sbb_pkg::t_result            o_pix_res,
    output sbb_pkg::t_summary           o_summary,
    output logic                        o_frame_end
);

    localparam int CW = sbb_pkg::COORD_W;
    localparam int PW = sbb_pkg::PIX_W;

    // Last valid coordinate for a programmed size; zero acts as one and
    // anything above the maximum acts as the maximum.
    function automatic logic [CW-1:0] dim_last(input logic [sbb_pkg::DIM_W-1:0] v);
        logic [sbb_pkg::DIM_W-1:0] m;
        m = v - 1'b1;
        if (v == '0) begin
            return '0;
        end else if (v > sbb_pkg::DIM_W'(sbb_pkg::MAX_DIM)) begin
            return CW'(sbb_pkg::MAX_DIM - 1);
        end else begin
            return m[CW-1:0];
        end
    endfunction

    logic [CW-1:0] r_col, r_row, n_col, n_row;
    logic [PW-1:0] r_at, r_left, n_at, n_left;
    logic [CW-1:0] r_box_l, r_box_t, r_box_r, r_box_b;
    logic [CW-1:0] n_box_l, n_box_t, n_box_r, n_box_b;
    logic          r_content, n_content;
    logic [CW-1:0] r_mark_x, r_mark_y, n_mark_x, n_mark_y;
    logic          r_mark_seen, n_mark_seen;
    logic [CW-1:0] r_rect_l, r_rect_t, r_rect_r, r_rect_b;
    logic [CW-1:0] n_rect_l, n_rect_t, n_rect_r, n_rect_b;
    logic          r_rect_seen, n_rect_seen;

    // Values after this pixel, before the end-of-frame clear.
    logic [CW-1:0] u_box_l, u_box_t, u_box_r, u_box_b;
    logic          u_content;
    logic [CW-1:0] u_mark_x, u_mark_y;
    logic          u_mark_seen;
    logic [CW-1:0] u_rect_l, u_rect_t, u_rect_r, u_rect_b;
    logic          u_rect_seen;

    logic [CW-1:0] w_last, h_last;
    logic [PW-1:0] at_now, pix_out;
    logic          col_end, row_end, frame_end;
    logic [CW-1:0] s_l, s_t, s_r, s_b, s_mx, s_my;

    always_comb begin
        w_last = dim_last(i_cfg.frame_width);
        h_last = dim_last(i_cfg.frame_height);

        if (r_col == '0 && r_row == '0) begin
            at_now = i_cfg.mode_flags[sbb_pkg::FLAG_TRANS_FIRST]
                   ? i_pixel : i_cfg.transparent_index;
        end else begin
            at_now = r_at;
        end

        pix_out     = i_pixel;
        u_box_l     = r_box_l;
        u_box_t     = r_box_t;
        u_box_r     = r_box_r;
        u_box_b     = r_box_b;
        u_content   = r_content;
        u_mark_x    = r_mark_x;
        u_mark_y    = r_mark_y;
        u_mark_seen = r_mark_seen;
        u_rect_l    = r_rect_l;
        u_rect_t    = r_rect_t;
        u_rect_r    = r_rect_r;
        u_rect_b    = r_rect_b;
        u_rect_seen = r_rect_seen;

        if (i_pixel != at_now) begin
            if (i_cfg.mode_flags[sbb_pkg::FLAG_CHECK_MARK]
                && i_pixel == i_cfg.mark_index) begin
                u_mark_y = r_row;
                if (!r_mark_seen) begin
                    u_mark_x = r_col;
                end
                u_mark_seen = 1'b1;
                // Internal mode copies the rewritten left neighbor, except
                // in the first column where there is none.
                if (i_cfg.mode_flags[sbb_pkg::FLAG_INTERNAL] && r_col != '0) begin
                    pix_out = r_left;
                end else begin
                    pix_out = at_now;
                end
            end else if (i_cfg.mode_flags[sbb_pkg::FLAG_TRACK_RECT]
                         && i_pixel == i_cfg.rect_index) begin
                if (!r_rect_seen) begin
                    u_rect_l = r_col;
                    u_rect_t = r_row;
                end
                u_rect_r    = r_col;
                u_rect_b    = r_row;
                u_rect_seen = 1'b1;
            end else begin
                if (!r_content) begin
                    u_box_l   = r_col;
                    u_box_t   = r_row;
                    u_box_r   = r_col;
                    u_content = 1'b1;
                end else begin
                    if (r_col < r_box_l) u_box_l = r_col;
                    if (r_col > r_box_r) u_box_r = r_col;
                end
                u_box_b = r_row;
            end
        end

        n_at   = at_now;
        n_left = pix_out;

        // A column or row beyond the last one also ends it, which covers a
        // size that shrank in the middle of a frame.
        col_end   = r_col >= w_last;
        row_end   = r_row >= h_last;
        frame_end = col_end && row_end;
        if (col_end) begin
            n_col = '0;
            n_row = row_end ? '0 : r_row + 1'b1;
        end else begin
            n_col = r_col + 1'b1;
            n_row = r_row;
        end

        if (!i_cfg.mode_flags[sbb_pkg::FLAG_CROP] || !u_content) begin
            s_l = '0;
            s_t = '0;
            s_r = w_last;
            s_b = h_last;
        end else begin
            s_l = u_box_l;
            s_t = u_box_t;
            s_r = u_box_r;
            s_b = u_box_b;
        end
        if (u_mark_seen) begin
            s_mx = u_mark_x;
            s_my = u_mark_y;
        end else begin
            s_mx = s_l;
            s_my = s_b;
            if (i_cfg.mode_flags[sbb_pkg::FLAG_MARGIN]) begin
                if (s_r < w_last) s_r = s_r + 1'b1;
                if (s_t != '0)    s_t = s_t - 1'b1;
            end
        end

        n_box_l     = u_box_l;
        n_box_t     = u_box_t;
        n_box_r     = u_box_r;
        n_box_b     = u_box_b;
        n_content   = u_content;
        n_mark_x    = u_mark_x;
        n_mark_y    = u_mark_y;
        n_mark_seen = u_mark_seen;
        n_rect_l    = u_rect_l;
        n_rect_t    = u_rect_t;
        n_rect_r    = u_rect_r;
        n_rect_b    = u_rect_b;
        n_rect_seen = u_rect_seen;
        if (frame_end) begin
            n_box_l     = '0;
            n_box_t     = '0;
            n_box_r     = '0;
            n_box_b     = '0;
            n_content   = 1'b0;
            n_mark_x    = '0;
            n_mark_y    = '0;
            n_mark_seen = 1'b0;
            n_rect_l    = '0;
            n_rect_t    = '0;
            n_rect_r    = '0;
            n_rect_b    = '0;
            n_rect_seen = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_at        <= '0;
            r_left      <= '0;
            r_box_l     <= '0;
            r_box_t     <= '0;
            r_box_r     <= '0;
            r_box_b     <= '0;
            r_content   <= 1'b0;
            r_mark_x    <= '0;
            r_mark_y    <= '0;
            r_mark_seen <= 1'b0;
            r_rect_l    <= '0;
            r_rect_t    <= '0;
            r_rect_r    <= '0;
            r_rect_b    <= '0;
            r_rect_seen <= 1'b0;
        end else if (i_accept) begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_at        <= n_at;
            r_left      <= n_left;
            r_box_l     <= n_box_l;
            r_box_t     <= n_box_t;
            r_box_r     <= n_box_r;
            r_box_b     <= n_box_b;
            r_content   <= n_content;
            r_mark_x    <= n_mark_x;
            r_mark_y    <= n_mark_y;
            r_mark_seen <= n_mark_seen;
            r_rect_l    <= n_rect_l;
            r_rect_t    <= n_rect_t;
            r_rect_r    <= n_rect_r;
            r_rect_b    <= n_rect_b;
            r_rect_seen <= n_rect_seen;
        end
    end

    always_comb begin
        o_pix_res           = '0;
        o_pix_res.kind      = sbb_pkg::KIND_PIXEL;
        o_pix_res.pixel_out = pix_out;
        o_pix_res.last      = !frame_end;

        o_summary = '0;
        o_summary.box.kind    = sbb_pkg::KIND_BOX;
        o_summary.box.coord_a = s_l;
        o_summary.box.coord_b = s_t;
        o_summary.box.coord_c = s_r;
        o_summary.box.coord_d = s_b;
        o_summary.box.found   = u_mark_seen;

        o_summary.mark.kind    = sbb_pkg::KIND_MARK;
        o_summary.mark.coord_a = s_mx;
        o_summary.mark.coord_b = s_my;
        o_summary.mark.found   = u_mark_seen;

        o_summary.rect.kind = sbb_pkg::KIND_RECT;
        o_summary.rect.last = 1'b1;
        if (u_rect_seen) begin
            o_summary.rect.coord_a = u_rect_l;
            o_summary.rect.coord_b = u_rect_t;
            o_summary.rect.coord_c = u_rect_r;
            o_summary.rect.coord_d = u_rect_b;
            o_summary.rect.found   = 1'b1;
        end
    end

    assign o_frame_end = frame_end;

endmodule

[src/sbb_out.sv]
// Output register and summary sequencer of the sprite bounding-box scanner.
// Depends on sbb_pkg; holds one result beat and queues the three summary beats.
module sbb_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  sbb_pkg::t_result     i_pix_res,
    input  sbb_pkg::t_summary    i_summary,
    input  logic                 i_frame_end,
    input  logic                 i_stall,
    output logic                 o_valid,
    output sbb_pkg::t_result     o_res,
    output sbb_pkg::t_out_status o_status
);

    logic              r_valid, n_valid;
    logic [1:0]        r_cnt, n_cnt;
    sbb_pkg::t_result  r_res, n_res;
    sbb_pkg::t_result  r_q0, r_q1, r_q2, n_q0, n_q1, n_q2;
    logic              take;

    assign take = r_valid && !i_stall;

    always_comb begin
        n_valid = r_valid;
        n_cnt   = r_cnt;
        n_res   = r_res;
        n_q0    = r_q0;
        n_q1    = r_q1;
        n_q2    = r_q2;
        if (i_accept) begin
            n_valid = 1'b1;
            n_res   = i_pix_res;
            if (i_frame_end) begin
                n_q0  = i_summary.box;
                n_q1  = i_summary.mark;
                n_q2  = i_summary.rect;
                n_cnt = 2'd3;
            end
        end else if (take) begin
            if (r_cnt != 2'd0) begin
                n_res = r_q0;
                n_q0  = r_q1;
                n_q1  = r_q2;
                n_cnt = r_cnt - 1'b1;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_q0  <= n_q0;
        r_q1  <= n_q1;
        r_q2  <= n_q2;
    end

    assign o_valid               = r_valid;
    assign o_res                 = r_res;
    assign o_status.holding      = r_valid && i_stall;
    assign o_status.summary_busy = r_cnt != 2'd0;

endmodule

[src/sprite_bounding_box_scanner.sv]
// Top level of the sprite bounding-box scanner.
// Depends on sbb_pkg, sbb_cfg, sbb_scan and sbb_out.
//
// Usage:
// Pixels of a frame arrive in scan order on i_pixel_in with i_valid and
// o_stall; a beat is taken at a clock edge where i_valid is high and o_stall
// is low. Results leave on o_kind .. o_last with o_valid and i_stall.
// Every pixel gives one pixel beat in the cycle after it is taken. The last
// pixel of a frame gives four beats: the pixel, then the crop box, the mark
// point and the rectangle, the last of them with o_last set.
// Throughput is one pixel per cycle while the receiver does not stall; the
// input also pauses while the summary beats drain from the output sequencer,
// when o_stall stays high.
// When the receiver stalls, the output register holds its beat and o_stall
// rises in the same cycle, so no beat is lost or repeated.
// The configuration port writes register i_cfg_addr from i_cfg_data at any
// edge with i_cfg_we high; write it only while the block is idle.
// Synchronous active-low reset clears the scan state and the output, and
// restores the configuration registers to their defaults.
module sprite_bounding_box_scanner (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sbb_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [sbb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [sbb_pkg::PIX_W-1:0]         i_pixel_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [sbb_pkg::KIND_W-1:0]        o_kind,
    output logic [sbb_pkg::PIX_W-1:0]         o_pixel_out,
    output logic [sbb_pkg::COORD_W-1:0]       o_coord_a,
    output logic [sbb_pkg::COORD_W-1:0]       o_coord_b,
    output logic [sbb_pkg::COORD_W-1:0]       o_coord_c,
    output logic [sbb_pkg::COORD_W-1:0]       o_coord_d,
    output logic                              o_found,
    output logic                              o_last
);

    sbb_pkg::t_cfg        cfg;
    sbb_pkg::t_result     pix_res;
    sbb_pkg::t_summary    summary;
    sbb_pkg::t_result     res;
    sbb_pkg::t_out_status out_status;
    logic                 frame_end;
    logic                 in_accept;

    assign o_stall   = out_status.holding || out_status.summary_busy;
    assign in_accept = i_valid && !o_stall;

    sbb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    sbb_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (in_accept),
        .i_pixel     (i_pixel_in),
        .o_pix_res   (pix_res),
        .o_summary   (summary),
        .o_frame_end (frame_end)
    );

    sbb_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_pix_res   (pix_res),
        .i_summary   (summary),
        .i_frame_end (frame_end),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_res       (res),
        .o_status    (out_status)
    );

    assign o_kind      = res.kind;
    assign o_pixel_out = res.pixel_out;
    assign o_coord_a   = res.coord_a;
    assign o_coord_b   = res.coord_b;
    assign o_coord_c   = res.coord_c;
    assign o_coord_d   = res.coord_d;
    assign o_found     = res.found;
    assign o_last      = res.last;

`ifndef SYNTHESIS
    // Box and mark beats are always followed by more summary beats.
    a_summary_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == sbb_pkg::KIND_BOX || o_kind == sbb_pkg::KIND_MARK)
        |-> o_stall && !o_last)
        else $error("summary beat shown while input not stalled or marked last");

    a_rect_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == sbb_pkg::KIND_RECT |-> o_last)
        else $error("rectangle beat without last");

    a_summary_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != sbb_pkg::KIND_PIXEL |-> o_pixel_out == '0)
        else $error("summary beat carries pixel data");

    // A pixel beat that closes a frame is followed by the box beat.
    a_box_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_kind == sbb_pkg::KIND_PIXEL && !o_last
        |=> o_valid && o_kind == sbb_pkg::KIND_BOX)
        else $error("frame end pixel not followed by crop box");
`endif

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench of sprite_bounding_box_scanner: feeds random frames, predicts
// the pixel, crop box, mark point and rectangle beats, and checks them in order.
// Depends on sbb_pkg and the scanner RTL; needs no files or arguments.
module testbench;

    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_CYCLES = 200;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [sbb_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [sbb_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           i_valid = 1'b0;
    logic                           o_stall;
    logic [sbb_pkg::PIX_W-1:0]      i_pixel_in = '0;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    logic [sbb_pkg::KIND_W-1:0]     o_kind;
    logic [sbb_pkg::PIX_W-1:0]      o_pixel_out;
    logic [sbb_pkg::COORD_W-1:0]    o_coord_a;
    logic [sbb_pkg::COORD_W-1:0]    o_coord_b;
    logic [sbb_pkg::COORD_W-1:0]    o_coord_c;
    logic [sbb_pkg::COORD_W-1:0]    o_coord_d;
    logic                           o_found;
    logic                           o_last;

    sprite_bounding_box_scanner dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel_in  (i_pixel_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_pixel_out (o_pixel_out),
        .o_coord_a   (o_coord_a),
        .o_coord_b   (o_coord_b),
        .o_coord_c   (o_coord_c),
        .o_coord_d   (o_coord_d),
        .o_found     (o_found),
        .o_last      (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Pixels waiting to be offered and beats the scanner still owes us.
    logic [sbb_pkg::PIX_W-1:0] pixel_q[$];
    sbb_pkg::t_result          expected_beats[$];

    logic in_beat = 1'b0;
    logic out_beat = 1'b0;
    logic sender_idles = 1'b1;
    logic receiver_idles = 1'b1;
    logic hold_armed = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   send_gap = 0;
    int   stall_gap = 0;
    int   quiet_cycles = 0;
    int   err_count = 0;
    int   pixels_taken = 0;
    int   frames_done = 0;
    int   beats_checked = 0;
    int   settings_count = 0;

    // Shadow of the configuration and of the scan state.
    sbb_pkg::t_cfg               cfg_shadow;
    logic [sbb_pkg::COORD_W-1:0] col_pos, row_pos;
    logic [sbb_pkg::PIX_W-1:0]   active_trans, left_pix;
    logic [sbb_pkg::COORD_W-1:0] box_l, box_t, box_r, box_b;
    logic [sbb_pkg::COORD_W-1:0] mark_x, mark_y;
    logic [sbb_pkg::COORD_W-1:0] rect_l, rect_t, rect_r, rect_b;
    logic                        content_seen, mark_seen, rect_seen;

    function automatic logic [sbb_pkg::DIM_W-1:0] clamp_dim(
        input logic [sbb_pkg::DIM_W-1:0] v);
        if (v == '0)
            return sbb_pkg::DIM_W'(1);
        if (v > sbb_pkg::DIM_W'(sbb_pkg::MAX_DIM))
            return sbb_pkg::DIM_W'(sbb_pkg::MAX_DIM);
        return v;
    endfunction

    task automatic clear_frame_state();
        col_pos = '0;
        row_pos = '0;
        {box_l, box_t, box_r, box_b} = '0;
        {mark_x, mark_y} = '0;
        {rect_l, rect_t, rect_r, rect_b} = '0;
        content_seen = 1'b0;
        mark_seen = 1'b0;
        rect_seen = 1'b0;
    endtask

    // Advances the shadow scan by one pixel and queues the beats it causes.
    task automatic scan_pixel(input logic [sbb_pkg::PIX_W-1:0] p);
        logic [sbb_pkg::DIM_W-1:0]   w, h;
        logic [sbb_pkg::COORD_W-1:0] w_last, h_last, l, t, r, b, mx, my;
        logic [sbb_pkg::FLAG_W-1:0]  mode;
        logic [sbb_pkg::PIX_W-1:0]   o;
        logic                        frame_end;
        sbb_pkg::t_result            beat;
        w = clamp_dim(cfg_shadow.frame_width);
        h = clamp_dim(cfg_shadow.frame_height);
        w_last = sbb_pkg::COORD_W'(w - 1'b1);
        h_last = sbb_pkg::COORD_W'(h - 1'b1);
        mode = cfg_shadow.mode_flags;
        o = p;
        frame_end = 1'b0;

        if (col_pos == '0 && row_pos == '0)
            active_trans = mode[sbb_pkg::FLAG_TRANS_FIRST] ? p
                         : cfg_shadow.transparent_index;

        if (p != active_trans) begin
            if (mode[sbb_pkg::FLAG_CHECK_MARK] && p == cfg_shadow.mark_index) begin
                mark_y = row_pos;
                if (!mark_seen)
                    mark_x = col_pos;
                mark_seen = 1'b1;
                o = (mode[sbb_pkg::FLAG_INTERNAL] && col_pos != '0) ? left_pix
                                                                     : active_trans;
            end else if (mode[sbb_pkg::FLAG_TRACK_RECT]
                         && p == cfg_shadow.rect_index) begin
                if (!rect_seen) begin
                    rect_l = col_pos;
                    rect_t = row_pos;
                end
                rect_r = col_pos;
                rect_b = row_pos;
                rect_seen = 1'b1;
            end else begin
                if (!content_seen) begin
                    box_l = col_pos;
                    box_t = row_pos;
                    box_r = col_pos;
                    content_seen = 1'b1;
                end else begin
                    if (col_pos < box_l)
                        box_l = col_pos;
                    if (col_pos > box_r)
                        box_r = col_pos;
                end
                box_b = row_pos;
            end
        end
        left_pix = o;

        // Row and frame ends compare against the size in force now, so a
        // shrink in the middle of a frame ends the row at once.
        if ({1'b0, col_pos} + 1'b1 >= w) begin
            col_pos = '0;
            if ({1'b0, row_pos} + 1'b1 >= h)
                frame_end = 1'b1;
            else
                row_pos = row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end

        beat = '0;
        beat.kind = sbb_pkg::KIND_PIXEL;
        beat.pixel_out = o;
        beat.last = !frame_end;
        expected_beats.push_back(beat);
        if (!frame_end)
            return;

        if (!mode[sbb_pkg::FLAG_CROP] || !content_seen) begin
            l = '0;
            t = '0;
            r = w_last;
            b = h_last;
        end else begin
            l = box_l;
            t = box_t;
            r = box_r;
            b = box_b;
        end
        if (mark_seen) begin
            mx = mark_x;
            my = mark_y;
        end else begin
            mx = l;
            my = b;
            if (mode[sbb_pkg::FLAG_MARGIN]) begin
                if (r < w_last)
                    r = r + 1'b1;
                if (t != '0)
                    t = t - 1'b1;
            end
        end

        beat = '0;
        beat.kind = sbb_pkg::KIND_BOX;
        beat.coord_a = l;
        beat.coord_b = t;
        beat.coord_c = r;
        beat.coord_d = b;
        beat.found = mark_seen;
        expected_beats.push_back(beat);

        beat = '0;
        beat.kind = sbb_pkg::KIND_MARK;
        beat.coord_a = mx;
        beat.coord_b = my;
        beat.found = mark_seen;
        expected_beats.push_back(beat);

        beat = '0;
        beat.kind = sbb_pkg::KIND_RECT;
        if (rect_seen) begin
            beat.coord_a = rect_l;
            beat.coord_b = rect_t;
            beat.coord_c = rect_r;
            beat.coord_d = rect_b;
            beat.found = 1'b1;
        end
        beat.last = 1'b1;
        expected_beats.push_back(beat);

        clear_frame_state();
        frames_done++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endtask

    task automatic check_beat();
        sbb_pkg::t_result want;
        if (expected_beats.size() == 0) begin
            $error("unexpected beat of kind %0d", o_kind);
            err_count++;
            return;
        end
        want = expected_beats.pop_front();
        check_field("kind", 32'(want.kind), 32'(o_kind));
        check_field("pixel_out", 32'(want.pixel_out), 32'(o_pixel_out));
        check_field("coord_a", 32'(want.coord_a), 32'(o_coord_a));
        check_field("coord_b", 32'(want.coord_b), 32'(o_coord_b));
        check_field("coord_c", 32'(want.coord_c), 32'(o_coord_c));
        check_field("coord_d", 32'(want.coord_d), 32'(o_coord_d));
        check_field("found", 32'(want.found), 32'(o_found));
        check_field("last", 32'(want.last), 32'(o_last));
        beats_checked++;
    endtask

    // Monitor: checks result beats, tracks register writes and predicts
    // from every pixel beat taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_shadow.frame_width = sbb_pkg::RST_FRAME_WIDTH;
            cfg_shadow.frame_height = sbb_pkg::RST_FRAME_HEIGHT;
            cfg_shadow.transparent_index = sbb_pkg::RST_TRANSPARENT;
            cfg_shadow.mark_index = sbb_pkg::RST_MARK_INDEX;
            cfg_shadow.rect_index = sbb_pkg::RST_RECT_INDEX;
            cfg_shadow.mode_flags = sbb_pkg::RST_MODE_FLAGS;
            active_trans = '0;
            left_pix = '0;
            clear_frame_state();
            in_beat <= 1'b0;
            out_beat <= 1'b0;
        end else begin
            in_beat <= i_valid && !o_stall;
            out_beat <= o_valid && !i_stall;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    sbb_pkg::REG_FRAME_WIDTH:
                        cfg_shadow.frame_width = i_cfg_data;
                    sbb_pkg::REG_FRAME_HEIGHT:
                        cfg_shadow.frame_height = i_cfg_data;
                    sbb_pkg::REG_TRANSPARENT:
                        cfg_shadow.transparent_index = i_cfg_data[sbb_pkg::PIX_W-1:0];
                    sbb_pkg::REG_MARK_INDEX:
                        cfg_shadow.mark_index = i_cfg_data[sbb_pkg::PIX_W-1:0];
                    sbb_pkg::REG_RECT_INDEX:
                        cfg_shadow.rect_index = i_cfg_data[sbb_pkg::PIX_W-1:0];
                    sbb_pkg::REG_MODE_FLAGS:
                        cfg_shadow.mode_flags = i_cfg_data[sbb_pkg::FLAG_W-1:0];
                    default: ;
                endcase
            end
            if (o_valid && !i_stall)
                check_beat();
            if (i_valid && !o_stall) begin
                scan_pixel(i_pixel_in);
                pixels_taken++;
            end
        end
    end

    // Driver: offers queued pixels, with a random gap after each beat while sender_idles is set.
    always @(negedge i_clk) begin
        if (!i_valid || in_beat) begin
            if (send_gap > 0) begin
                i_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pixel_q.size() != 0) begin
                i_valid <= 1'b1;
                i_pixel_in <= pixel_q.pop_front();
                send_gap <= sender_idles ? $urandom_range(0, 9) : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: draws a random stall after each beat while receiver_idles is set,
    // or stalls for a long stretch once the hold is armed.
    always @(negedge i_clk) begin : receiver
        int draw;
        if (hold_armed && !hold_done) begin
            i_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (out_beat) begin
            draw = receiver_idles ? $urandom_range(0, 9) : 0;
            i_stall <= (draw != 0);
            stall_gap <= (draw != 0) ? draw - 1 : 0;
        end else if (stall_gap > 0) begin
            i_stall <= 1'b1;
            stall_gap <= stall_gap - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [sbb_pkg::CFG_ADDR_W-1:0] idx,
                             input int unsigned value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value[sbb_pkg::CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(input int unsigned w, input int unsigned h,
                             input int unsigned trans, input int unsigned mark,
                             input int unsigned rect, input int unsigned flags);
        write_reg(sbb_pkg::REG_FRAME_WIDTH, w);
        write_reg(sbb_pkg::REG_FRAME_HEIGHT, h);
        write_reg(sbb_pkg::REG_TRANSPARENT, trans);
        write_reg(sbb_pkg::REG_MARK_INDEX, mark);
        write_reg(sbb_pkg::REG_RECT_INDEX, rect);
        write_reg(sbb_pkg::REG_MODE_FLAGS, flags);
        settings_count++;
        @(posedge i_clk);
    endtask

    // Waits until every pixel is taken and every beat has come back.
    task automatic settle();
        @(posedge i_clk);
        while (pixel_q.size() != 0 || i_valid || expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    // Queues one whole frame; spread sets how rare non-background pixels are.
    task automatic queue_frame(input int w, input int h, input int spread);
        logic [sbb_pkg::PIX_W-1:0] bg, p;
        int                        n;
        bg = cfg_shadow.transparent_index;
        for (int i = 0; i < w * h; i++) begin
            n = $urandom_range(0, spread);
            if (n == 0)
                p = cfg_shadow.mark_index;
            else if (n == 1)
                p = cfg_shadow.rect_index;
            else if (n <= 4)
                p = sbb_pkg::PIX_W'($urandom_range(0, 255));
            else
                p = bg;
            if (i == 0 && cfg_shadow.mode_flags[sbb_pkg::FLAG_TRANS_FIRST])
                bg = p;
            pixel_q.push_back(p);
        end
    endtask

    initial begin
        logic [sbb_pkg::PIX_W-1:0] sample [0:11];
        int                        w, h, phase_pixels;
        int unsigned               mark, rect;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default registers: one-pixel frames, so every pixel closes a frame.
        pixel_q.push_back(8'h00);
        pixel_q.push_back(8'hFF);
        pixel_q.push_back(8'hFE);
        pixel_q.push_back(8'h80);
        settle();

        // Zero sizes act as one.
        configure(0, 0, 8'hFF, 8'h00, 8'h01, 6'h00);
        pixel_q.push_back(8'h00);
        pixel_q.push_back(8'hFF);
        settle();

        // All modes on; background taken from the first pixel. Marks sit at
        // column zero and inside rows so both rewrite paths are used.
        configure(4, 3, 8'h00, 8'hFF, 8'hFE, 6'h3F);
        sample = '{8'h10, 8'hFF, 8'hFE, 8'h33,
                   8'hFF, 8'h10, 8'h44, 8'hFE,
                   8'h00, 8'hFF, 8'h10, 8'h55};
        for (int i = 0; i < 12; i++)
            pixel_q.push_back(sample[i]);
        settle();

        // Width shrinks in the middle of a frame, past the current column.
        configure(6, 2, 8'h00, 8'hFF, 8'hFE, 6'h09);
        for (int i = 0; i < 4; i++)
            pixel_q.push_back(sbb_pkg::PIX_W'(8'h20 + i));
        settle();
        write_reg(sbb_pkg::REG_FRAME_WIDTH, 2);
        for (int i = 0; i < 3; i++)
            pixel_q.push_back(sbb_pkg::PIX_W'(8'h30 + i));
        settle();

        // Random small frames under random settings and idling patterns.
        for (int phase = 0; phase < 8; phase++) begin
            w = $urandom_range(1, 10);
            h = $urandom_range(1, 6);
            mark = $urandom_range(0, 255);
            rect = ($urandom_range(0, 3) == 0) ? mark : $urandom_range(0, 255);
            configure(w, h, $urandom_range(0, 255), mark, rect, $urandom_range(0, 63));
            sender_idles = !phase[0];
            receiver_idles = !phase[1];
            phase_pixels = 0;
            while (phase_pixels < 18) begin
                queue_frame(w, h, 9);
                phase_pixels += w * h;
            end
            // With both sides busy, hold the output long enough to back up
            // the input.
            if (phase == 3)
                hold_armed = 1'b1;
            settle();
        end

        // Oversized registers act as the maximum, so a few pixels stay in
        // one row; a zero size written afterwards acts as one and closes it.
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        configure(8191, 8191, 8'h00, 8'hFF, 8'hFE, 6'h1F);
        pixel_q.push_back(8'h00);
        pixel_q.push_back(8'h12);
        pixel_q.push_back(8'hFF);
        pixel_q.push_back(8'hFE);
        pixel_q.push_back(8'h34);
        pixel_q.push_back(8'hFF);
        settle();
        write_reg(sbb_pkg::REG_FRAME_WIDTH, 0);
        write_reg(sbb_pkg::REG_FRAME_HEIGHT, 0);
        pixel_q.push_back(8'h44);
        settle();

        $display("Scanned %0d pixels in %0d frames under %0d register settings.",
                 pixels_taken, frames_done, settings_count);
        $display("Checked %0d result beats, including a mid-frame resize and a long output hold.",
                 beats_checked);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
